>>> sv/plc_pkg.sv
`default_nettype none
package plc_pkg;

   // fixed field widths of the request and response beats
   localparam int KIND_WIDTH   = 2;
   localparam int POS_WIDTH    = 7;
   localparam int FIELD_WIDTH  = 32;
   localparam int STATUS_WIDTH = 2;
   localparam int COUNT_WIDTH  = 7;

   // request kinds
   localparam logic [KIND_WIDTH-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_GET    = 2'd2;

   // response status codes
   localparam logic [STATUS_WIDTH-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd2;

   // shift command broadcast to every cell
   typedef struct packed {
      logic                 ins;
      logic                 rem;
      logic [POS_WIDTH-1:0] position;
   } cell_ctrl_type;

endpackage
`default_nettype wire

>>> sv/plc_cell.sv
`default_nettype none
module plc_cell
   import plc_pkg::*;
#(
   parameter int INDEX      = 0,
   parameter int DATA_WIDTH = 32,
   parameter int CMP_WIDTH  = 7
) (
   input  wire logic                  clock,
   input  wire cell_ctrl_type         ctrl,
   input  wire logic [DATA_WIDTH-1:0] ins_data,
   input  wire logic [DATA_WIDTH-1:0] left_data,
   input  wire logic [DATA_WIDTH-1:0] right_data,
   output      logic [DATA_WIDTH-1:0] data
);

   localparam logic [CMP_WIDTH-1:0] MY_INDEX = CMP_WIDTH'(INDEX);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;
   logic [CMP_WIDTH-1:0]  pos_ext;

   assign pos_ext = CMP_WIDTH'(ctrl.position);

   // pick own word, neighbor's word or the new word
   always_comb begin
      data_in = data_ff;
      if (ctrl.ins && pos_ext == MY_INDEX) begin
         data_in = ins_data;
      end else if (ctrl.ins && pos_ext < MY_INDEX) begin
         data_in = left_data;
      end else if (ctrl.rem && pos_ext <= MY_INDEX) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule
`default_nettype wire

>>> sv/positional_list_insert_remove_get.sv
// response: a response beat is valid in the cycle after its request beat is accepted
// throughput: one request per cycle while the output register is empty or its beat is taken;
//   every cell shifts in the same cycle, so the chain of cells sets no extra wait for insert, remove or get
// reset: clears the entry count and the response valid; the stored words
//   stay undefined until an insert writes them
`default_nettype none
module positional_list_insert_remove_get
   import plc_pkg::*;
#(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_ready,
   input  wire logic [KIND_WIDTH-1:0]   req_kind,
   input  wire logic [POS_WIDTH-1:0]    req_position,
   input  wire logic [FIELD_WIDTH-1:0]  req_value,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   output      logic [FIELD_WIDTH-1:0]  rsp_read_value,
   output      logic [STATUS_WIDTH-1:0] rsp_status,
   output      logic [COUNT_WIDTH-1:0]  rsp_count
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_WIDTH) ? CNT_W : POS_WIDTH;
   localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

   logic [DATA_WIDTH-1:0]   cell_q [CAPACITY];
   logic [DATA_WIDTH-1:0]   ins_word;
   logic [FIELD_WIDTH-1:0]  rd_word;
   cell_ctrl_type           ctrl;

   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [FIELD_WIDTH-1:0]  rsp_read_value_ff, rsp_read_value_in;
   logic [STATUS_WIDTH-1:0] rsp_status_ff, rsp_status_in;
   logic [COUNT_WIDTH-1:0]  rsp_count_ff, rsp_count_in;

   logic                    req_accept;
   logic [CMP_W-1:0]        pos_ext, cnt_ext;
   logic [IDX_W-1:0]        rd_idx;
   logic                    insert_ok, remove_ok, get_ok;

   // handshake: output register frees when its beat is taken
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   assign pos_ext = CMP_W'(req_position);
   assign cnt_ext = CMP_W'(count_ff);
   assign rd_idx  = IDX_W'(req_position);

   // width conversion of the incoming word
   generate
      if (DATA_WIDTH <= FIELD_WIDTH) begin : g_ins_trunc
         assign ins_word = req_value[DATA_WIDTH-1:0];
      end else begin : g_ins_sext
         assign ins_word = {{(DATA_WIDTH-FIELD_WIDTH){req_value[FIELD_WIDTH-1]}}, req_value};
      end
   endgenerate

   // width conversion of the word read out
   generate
      if (DATA_WIDTH >= FIELD_WIDTH) begin : g_rd_trunc
         assign rd_word = cell_q[rd_idx][FIELD_WIDTH-1:0];
      end else begin : g_rd_sext
         assign rd_word = {{(FIELD_WIDTH-DATA_WIDTH){cell_q[rd_idx][DATA_WIDTH-1]}},
                           cell_q[rd_idx]};
      end
   endgenerate

   // request decode and range checks
   always_comb begin
      insert_ok         = 1'b0;
      remove_ok         = 1'b0;
      get_ok            = 1'b0;
      rsp_status_in     = ST_DONE;
      case (req_kind)
         KIND_INSERT: begin
            if (pos_ext > cnt_ext) begin
               rsp_status_in = ST_RANGE;
            end else if (count_ff == CAP_COUNT) begin
               rsp_status_in = ST_FULL;
            end else begin
               insert_ok = 1'b1;
            end
         end
         KIND_REMOVE: begin
            if (pos_ext >= cnt_ext) begin
               rsp_status_in = ST_RANGE;
            end else begin
               remove_ok = 1'b1;
            end
         end
         KIND_GET: begin
            if (pos_ext >= cnt_ext) begin
               rsp_status_in = ST_RANGE;
            end else begin
               get_ok = 1'b1;
            end
         end
         default: begin
            rsp_status_in = ST_RANGE;
         end
      endcase
   end

   // shift command for the cells
   assign ctrl.ins      = req_accept && insert_ok;
   assign ctrl.rem      = req_accept && remove_ok;
   assign ctrl.position = req_position;

   // entry count
   always_comb begin
      count_in = count_ff;
      if (ctrl.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.rem) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // response beat contents
   assign rsp_read_value_in = get_ok ? rd_word : '0;
   assign rsp_count_in      = COUNT_WIDTH'(count_in);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_read_value_ff <= rsp_read_value_in;
         rsp_status_ff     <= rsp_status_in;
         rsp_count_ff      <= rsp_count_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;

   // chain of cells, each linked to the neighbors it has
   generate
      for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
         logic [DATA_WIDTH-1:0] left_data;
         logic [DATA_WIDTH-1:0] right_data;
         if (i == 0) begin : g_first
            assign left_data = ins_word;
         end else begin : g_left
            assign left_data = cell_q[i-1];
         end
         if (i == CAPACITY - 1) begin : g_last
            assign right_data = cell_q[i];
         end else begin : g_right
            assign right_data = cell_q[i+1];
         end
         plc_cell #(
            .INDEX      (i),
            .DATA_WIDTH (DATA_WIDTH),
            .CMP_WIDTH  (CMP_W)
         ) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .ins_data   (ins_word),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_q[i])
         );
      end
   endgenerate

   // count never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_COUNT)
      else $error("entry count above capacity");

   // a successful insert grows the count by one
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (req_accept && insert_ok) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow the count");

   // a full status is only given while the list is at capacity
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_FULL) |-> (count_ff == CAP_COUNT))
      else $error("full status with room left");

   // out-of-range and full beats carry a zero word
   a_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_DONE) |-> (rsp_read_value_ff == '0))
      else $error("failed request returned a word");

endmodule
`default_nettype wire

>>> tb/tb.sv
module tb;
   import plc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_DEPTH     = 64;
   localparam int LIST_IDX_W     = $clog2(LIST_DEPTH);
   localparam int RANDOM_ITEMS   = 1625;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 10;

   // kind code with no operation behind it
   localparam logic [KIND_WIDTH-1:0] KIND_UNKNOWN = 2'd3;

   // random phase shapes
   localparam int PHASE_FILL  = 0;
   localparam int PHASE_MIXED = 1;
   localparam int PHASE_DRAIN = 2;

   typedef struct packed {
      logic [KIND_WIDTH-1:0]  kind;
      logic [POS_WIDTH-1:0]   position;
      logic [FIELD_WIDTH-1:0] value;
   } list_req_type;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0]  read_value;
      logic [STATUS_WIDTH-1:0] status;
      logic [COUNT_WIDTH-1:0]  count;
   } list_rsp_type;

   logic                    clock          = 1'b0;
   logic                    reset          = 1'b1;
   logic                    req_valid      = 1'b0;
   logic                    req_ready;
   logic [KIND_WIDTH-1:0]   req_kind       = '0;
   logic [POS_WIDTH-1:0]    req_position   = '0;
   logic [FIELD_WIDTH-1:0]  req_value      = '0;
   logic                    rsp_valid;
   logic                    rsp_ready      = 1'b0;
   logic [FIELD_WIDTH-1:0]  rsp_read_value;
   logic [STATUS_WIDTH-1:0] rsp_status;
   logic [COUNT_WIDTH-1:0]  rsp_count;

   list_req_type req_pending_q[$];
   list_rsp_type rsp_expected_q[$];

   // predicted list contents and length
   logic [FIELD_WIDTH-1:0] list_words[LIST_DEPTH];
   int                     list_len = 0;

   // generator's own view of the length, used only to shape positions
   int gen_len = 0;

   bit failed = 1'b0;

   positional_list_insert_remove_get #(
      .CAPACITY   (LIST_DEPTH),
      .DATA_WIDTH (FIELD_WIDTH)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // range and capacity checks for one request against a list length
   function automatic logic [STATUS_WIDTH-1:0] list_op_status(
      logic [KIND_WIDTH-1:0] kind, logic [POS_WIDTH-1:0] pos, int len);
      case (kind)
         KIND_INSERT: begin
            if (pos > len) return ST_RANGE;
            if (len >= LIST_DEPTH) return ST_FULL;
            return ST_DONE;
         end
         KIND_REMOVE, KIND_GET: begin
            return (pos >= len) ? ST_RANGE : ST_DONE;
         end
         default: begin
            return ST_RANGE;
         end
      endcase
   endfunction

   // apply one request to the predicted list and return the response it gives
   function automatic list_rsp_type apply_list_op(list_req_type r);
      list_rsp_type rsp;
      rsp.read_value = '0;
      rsp.status     = list_op_status(r.kind, r.position, list_len);
      if (rsp.status == ST_DONE) begin
         case (r.kind)
            KIND_INSERT: begin
               for (int i = list_len; i > r.position; i--)
                  list_words[i] = list_words[i-1];
               list_words[LIST_IDX_W'(r.position)] = r.value;
               list_len++;
            end
            KIND_REMOVE: begin
               for (int i = r.position; i < list_len - 1; i++)
                  list_words[i] = list_words[i+1];
               list_len--;
            end
            default: begin
               rsp.read_value = list_words[LIST_IDX_W'(r.position)];
            end
         endcase
      end
      rsp.count = COUNT_WIDTH'(list_len);
      return rsp;
   endfunction

   // queue one request and track the length it leaves behind
   task automatic queue_request(logic [KIND_WIDTH-1:0] kind, logic [POS_WIDTH-1:0] pos,
                                logic [FIELD_WIDTH-1:0] value);
      list_req_type r;
      r.kind     = kind;
      r.position = pos;
      r.value    = value;
      if (list_op_status(kind, pos, gen_len) == ST_DONE) begin
         if (kind == KIND_INSERT) gen_len++;
         else if (kind == KIND_REMOVE) gen_len--;
      end
      req_pending_q.push_back(r);
   endtask

   // words biased toward the extremes
   function automatic logic [FIELD_WIDTH-1:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // stimulus, then wait for the last response
   initial begin
      int                    mode;
      int                    phase_num;
      int                    tail;
      int                    roll;
      int                    n_random;
      logic [KIND_WIDTH-1:0] kind;
      logic [POS_WIDTH-1:0]  pos;

      // empty list, bad positions and the unused kind
      queue_request(KIND_GET,    7'd0,   32'h1234_5678);
      queue_request(KIND_REMOVE, 7'd0,   32'h0);
      queue_request(KIND_INSERT, 7'd1,   32'h1);
      queue_request(KIND_UNKNOWN, 7'd0,  32'h0);
      // build a short list: front, back, middle inserts with extreme words
      queue_request(KIND_INSERT, 7'd0,   32'h7FFF_FFFF);
      queue_request(KIND_INSERT, 7'd1,   32'h8000_0000);
      queue_request(KIND_INSERT, 7'd0,   32'hFFFF_FFFF);
      queue_request(KIND_INSERT, 7'd1,   32'h0000_0000);
      queue_request(KIND_INSERT, 7'd2,   32'h5555_5555);
      queue_request(KIND_INSERT, 7'd5,   32'hAAAA_AAAA);
      // reads inside, just past the end and far past it
      queue_request(KIND_GET,    7'd0,   32'h0);
      queue_request(KIND_GET,    7'd5,   32'h0);
      queue_request(KIND_GET,    7'd3,   32'hFFFF_FFFF);
      queue_request(KIND_GET,    7'd6,   32'h0);
      queue_request(KIND_GET,    7'd127, 32'h0);
      // removes: past the end, middle, last, first
      queue_request(KIND_REMOVE, 7'd6,   32'h0);
      queue_request(KIND_REMOVE, 7'd2,   32'h0);
      queue_request(KIND_REMOVE, 7'd4,   32'h0);
      queue_request(KIND_REMOVE, 7'd0,   32'h0);
      queue_request(KIND_INSERT, 7'd127, 32'h7FFF_FFFF);
      queue_request(KIND_UNKNOWN, 7'd127, 32'hFFFF_FFFF);
      queue_request(KIND_GET,    7'd2,   32'h0);

      // random phases: fill to full, mixed traffic, drain to empty
      n_random  = 0;
      phase_num = 0;
      while (n_random < RANDOM_ITEMS) begin
         mode = phase_num % 3;
         phase_num++;
         tail = (mode == PHASE_MIXED) ? $urandom_range(60, 160) : $urandom_range(10, 40);
         while (n_random < RANDOM_ITEMS && tail > 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
               // noise: any kind, any position
               kind = KIND_WIDTH'($urandom);
               pos  = POS_WIDTH'($urandom);
            end else begin
               roll = $urandom_range(0, 99);
               case (mode)
                  PHASE_FILL:
                     kind = (roll < 75) ? KIND_INSERT : (roll < 87) ? KIND_GET : KIND_REMOVE;
                  PHASE_DRAIN:
                     kind = (roll < 70) ? KIND_REMOVE : (roll < 85) ? KIND_GET : KIND_INSERT;
                  default:
                     kind = (roll < 34) ? KIND_INSERT : (roll < 67) ? KIND_GET : KIND_REMOVE;
               endcase
               if (kind == KIND_INSERT)
                  pos = POS_WIDTH'($urandom_range(0, gen_len));
               else
                  pos = (gen_len > 0) ? POS_WIDTH'($urandom_range(0, gen_len - 1)) : 7'd0;
            end
            queue_request(kind, pos, pick_word());
            n_random++;
            if ((mode == PHASE_FILL && gen_len == LIST_DEPTH) ||
                (mode == PHASE_DRAIN && gen_len == 0) || mode == PHASE_MIXED)
               tail--;
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (req_pending_q.size() > 0 || req_valid || rsp_expected_q.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      // every predicted beat must have been seen
      if (rsp_expected_q.size() != 0 || req_pending_q.size() != 0) begin
         $display("%0t: beats missing: expected %0d actual %0d", $time,
                  0, rsp_expected_q.size() + req_pending_q.size());
         failed = 1'b1;
      end
      if (!failed) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // request driver: bursts of beats separated by random gaps
   always @(posedge clock) begin : drive_req
      int           burst_left;
      int           gap_left;
      logic         drive_next;
      list_req_type r;
      if (reset) begin
         burst_left = $urandom_range(1, 24);
         gap_left   = 0;
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         drive_next = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (req_pending_q.size() > 0) begin
            r = req_pending_q.pop_front();
            req_kind     <= r.kind;
            req_position <= r.position;
            req_value    <= r.value;
            drive_next   = 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
         req_valid <= drive_next;
      end
   end

   // response ready follows a rotating stall pattern that changes now and then
   always @(posedge clock) begin : drive_rsp_ready
      int         pattern_age;
      logic [7:0] stall_pattern;
      if (reset) begin
         pattern_age   = 0;
         stall_pattern = 8'hFF;
         rsp_ready    <= 1'b0;
      end else begin
         if (pattern_age == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pattern = 8'hFF;
               1: stall_pattern = 8'h01;
               2: stall_pattern = 8'h0F;
               default: stall_pattern = 8'($urandom) | 8'h01;
            endcase
            pattern_age = $urandom_range(20, 120);
         end
         pattern_age--;
         stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
         rsp_ready <= stall_pattern[0];
      end
   end

   // predict on each request beat, check each response beat
   always @(posedge clock) begin : check_rsp
      list_req_type r;
      list_rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            r.kind     = req_kind;
            r.position = req_position;
            r.value    = req_value;
            rsp_expected_q.push_back(apply_list_op(r));
         end
         if (rsp_valid && rsp_ready) begin
            if (rsp_expected_q.size() == 0) begin
               $display("%0t: unexpected response beat: read_value %0d status %0d count %0d",
                        $time, $signed(rsp_read_value), rsp_status, rsp_count);
               failed = 1'b1;
            end else begin
               want = rsp_expected_q.pop_front();
               if (rsp_read_value !== want.read_value) begin
                  $display("%0t: read_value mismatch: expected %0d actual %0d", $time,
                           $signed(want.read_value), $signed(rsp_read_value));
                  failed = 1'b1;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status mismatch: expected %0d actual %0d", $time,
                           want.status, rsp_status);
                  failed = 1'b1;
               end
               if (rsp_count !== want.count) begin
                  $display("%0t: count mismatch: expected %0d actual %0d", $time,
                           want.count, rsp_count);
                  failed = 1'b1;
               end
            end
         end
      end
   end

   // watchdog: too long without any beat on either channel
   always @(posedge clock) begin : watchdog
      int idle_cycles;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
         end
      end
   end

endmodule
